[rtl/servo_slew_and_tail_wag_assert.svh]
// assertion macros shared by the servo block
`ifndef SERVO_SLEW_AND_TAIL_WAG_ASSERT_SVH
`define SERVO_SLEW_AND_TAIL_WAG_ASSERT_SVH

// property must hold at every clock edge outside reset
`define SSW_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be true outside reset
`define SSW_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/ssw_pkg.sv]
package ssw_pkg;

  localparam int CHANNELS = 5;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAIL_CH  = CHANNELS - 1;
  localparam int MIRROR_A = 2;
  localparam int MIRROR_B = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] ANGLE_MAX = 8'd180;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_TAIL = 2'd2;

  localparam logic [2:0] CFG_TAIL_HIGH = 3'd0;
  localparam logic [2:0] CFG_TAIL_LOW  = 3'd1;
  localparam logic [2:0] CFG_SPEED_MIN = 3'd2;
  localparam logic [2:0] CFG_SPEED_MAX = 3'd3;
  localparam logic [2:0] CFG_WAG_COUNT = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_TAIL
  } op_e;

  typedef struct packed {
    logic [7:0] tail_high;
    logic [7:0] tail_low;
    logic [7:0] speed_min;
    logic [7:0] speed_max;
    logic [6:0] wag_count;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] ch;
    logic [7:0]      tgt;
    logic [7:0]      step;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] reset_cur(int i);
    if (i == TAIL_CH) return 8'd0;
    if (i == 1 || i == 2) return 8'd155;
    return 8'd90;
  endfunction

  function automatic logic [7:0] reset_tgt(int i);
    if (i == TAIL_CH) return 8'd90;
    if (i == 1 || i == 2) return 8'd155;
    return 8'd90;
  endfunction

  function automatic logic [7:0] reset_step(int i);
    if (i == TAIL_CH) return 8'd0;
    return 8'd1;
  endfunction

  function automatic logic is_mirror(logic [CH_W-1:0] i);
    int n;
    n = int'(i);
    return (n == MIRROR_A || n == MIRROR_B) && (n != TAIL_CH);
  endfunction

endpackage

[rtl/servo_slew_and_tail_wag.sv]
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   cmd_i channel_i position_i speed_i
// out      output     out_valid_o / out_stall_i out_channel_o angle_o last_o
// cfg      input      cfg_we_i                  cfg_idx_i cfg_wdata_i
//
// set and tail words are handled in the idle state; a tick first updates the tail swing,
// then steps one channel per cycle, unless the output stalls, through a single shared
// step unit and the output register
// a two-word queue lets the input keep accepting while a tick runs
// reset puts every channel and config register at its start value at once
// an output stall holds the step unit, the input stalls only when the queue is full
module servo_slew_and_tail_wag (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [2:0]         channel_i,
  input  logic signed [15:0] position_i,
  input  logic [7:0]         speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_channel_o,
  output logic [7:0]         angle_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);
  import ssw_pkg::*;

  cfg_t   cfg_q;
  qstat_t qstat;
  entry_t push_entry, head_entry;
  logic   push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tail_high <= 8'd120;
      cfg_q.tail_low  <= 8'd60;
      cfg_q.speed_min <= 8'd1;
      cfg_q.speed_max <= 8'd10;
      cfg_q.wag_count <= 7'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAIL_HIGH: cfg_q.tail_high <= cfg_wdata_i;
        CFG_TAIL_LOW:  cfg_q.tail_low  <= cfg_wdata_i;
        CFG_SPEED_MIN: cfg_q.speed_min <= cfg_wdata_i;
        CFG_SPEED_MAX: cfg_q.speed_max <= cfg_wdata_i;
        CFG_WAG_COUNT: cfg_q.wag_count <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  ssw_front u_front (
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .channel_i  (channel_i),
    .position_i (position_i),
    .speed_i    (speed_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ssw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  ssw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .qstat_i       (qstat),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_channel_o (out_channel_o),
    .angle_o       (angle_o),
    .last_o        (last_o)
  );

endmodule

[rtl/ssw_front.sv]
module ssw_front (
  input  logic                 in_valid_i,
  input  logic [1:0]           cmd_i,
  input  logic [2:0]           channel_i,
  input  logic signed [15:0]   position_i,
  input  logic [7:0]           speed_i,
  input  ssw_pkg::cfg_t        cfg_i,
  input  ssw_pkg::qstat_t      qstat_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output ssw_pkg::entry_t      entry_o
);
  import ssw_pkg::*;

  logic       keep;
  logic [7:0] tgt_clamp;
  logic [7:0] step_clamp;

  always_comb begin
    if (position_i < 16'sd0) begin
      tgt_clamp = 8'd0;
    end else if (position_i > 16'sd180) begin
      tgt_clamp = ANGLE_MAX;
    end else begin
      tgt_clamp = position_i[7:0];
    end

    priority if (speed_i < cfg_i.speed_min) begin
      step_clamp = cfg_i.speed_min;
    end else if (speed_i > cfg_i.speed_max) begin
      step_clamp = cfg_i.speed_max;
    end else begin
      step_clamp = speed_i;
    end

    entry_o.ch   = CH_W'(channel_i);
    entry_o.tgt  = tgt_clamp;
    entry_o.step = step_clamp;
    keep         = 1'b0;
    entry_o.op   = OP_TICK;
    unique case (cmd_i)
      CMD_TICK: begin
        keep = 1'b1;
      end
      CMD_SET: begin
        entry_o.op = OP_SET;
        keep       = (int'(channel_i) < CHANNELS);
      end
      CMD_TAIL: begin
        entry_o.op   = OP_TAIL;
        entry_o.step = (speed_i > ANGLE_MAX) ? ANGLE_MAX : speed_i;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // unused codes and bad channels are taken and dropped
  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full && keep;

endmodule

[rtl/ssw_queue.sv]
module ssw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssw_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output ssw_pkg::entry_t  entry_o,
  output ssw_pkg::qstat_t  qstat_o
);
  import ssw_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign entry_o       = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);

  `include "servo_slew_and_tail_wag_assert.svh"

  `SSW_NEVER(a_push_full, clk_i, rst_ni, push_i && qstat_o.full, "push into full queue")
  `SSW_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && qstat_o.empty, "pop from empty queue")
  `SSW_ASSERT(a_cnt_up, clk_i, rst_ni, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

[rtl/ssw_back.sv]
module ssw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssw_pkg::cfg_t    cfg_i,
  input  ssw_pkg::qstat_t  qstat_i,
  input  ssw_pkg::entry_t  entry_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [2:0]       out_channel_o,
  output logic [7:0]       angle_o,
  output logic             last_o
);
  import ssw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  localparam logic [CH_W-1:0] TAIL_IDX = CH_W'(TAIL_CH);

  state_e          state_q;
  logic [CH_W-1:0] idx_q;
  logic [7:0]      cur_q  [CHANNELS];
  logic [7:0]      tgt_q  [CHANNELS];
  logic [7:0]      step_q [CHANNELS];
  logic            rev_q;
  logic [7:0]      hcnt_q;
  logic            out_valid_q;
  logic [2:0]      out_ch_q;
  logic [7:0]      angle_q;
  logic            last_q;

  logic       load;
  logic [7:0] c, t, s, nxt, ang;
  logic [7:0] tail_cur, wag_limit, wag_tgt, wag_cnt;
  logic       wag_stop, wag_rev;

  // one channel step per cycle while the output is not stalled
  always_comb begin
    c = cur_q[idx_q];
    t = tgt_q[idx_q];
    s = step_q[idx_q];
    if (c < t) begin
      nxt = (s >= t - c) ? t : c + s;
    end else if (c > t) begin
      nxt = (s >= c - t) ? t : c - s;
    end else begin
      nxt = c;
    end
    ang = is_mirror(idx_q) ? ANGLE_MAX - nxt : nxt;
  end

  // tail swing update at the start of a tick
  always_comb begin
    tail_cur  = cur_q[TAIL_IDX];
    wag_limit = {cfg_i.wag_count, 1'b0};
    wag_stop  = (hcnt_q >= wag_limit);
    wag_tgt   = tgt_q[TAIL_IDX];
    wag_rev   = rev_q;
    wag_cnt   = hcnt_q;
    if (!wag_rev && tail_cur < cfg_i.tail_high) begin
      wag_tgt = cfg_i.tail_high;
    end
    if (!wag_rev && tail_cur >= cfg_i.tail_high) begin
      wag_rev = 1'b1;
      wag_cnt = wag_cnt + 1'b1;
    end
    if (wag_rev && tail_cur > cfg_i.tail_low) begin
      wag_tgt = cfg_i.tail_low;
    end
    if (wag_rev && tail_cur <= cfg_i.tail_low) begin
      wag_rev = 1'b0;
      wag_cnt = wag_cnt + 1'b1;
    end
  end

  assign pop_o = (state_q == S_IDLE) && !qstat_i.empty;
  assign load  = (state_q == S_RUN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rev_q       <= 1'b0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      angle_q     <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_q[i]  <= reset_cur(i);
        tgt_q[i]  <= reset_tgt(i);
        step_q[i] <= reset_step(i);
      end
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        out_ch_q    <= 3'(idx_q);
        angle_q     <= ang;
        last_q      <= (idx_q == TAIL_IDX);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            unique case (entry_i.op)
              OP_SET: begin
                tgt_q[entry_i.ch]  <= entry_i.tgt;
                step_q[entry_i.ch] <= entry_i.step;
              end
              OP_TAIL: begin
                step_q[TAIL_IDX] <= entry_i.step;
              end
              OP_TICK: begin
                if (step_q[TAIL_IDX] != '0) begin
                  if (wag_stop) begin
                    step_q[TAIL_IDX] <= '0;
                    hcnt_q           <= '0;
                  end else begin
                    tgt_q[TAIL_IDX] <= wag_tgt;
                    rev_q           <= wag_rev;
                    hcnt_q          <= wag_cnt;
                  end
                end
                idx_q   <= '0;
                state_q <= S_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          if (load) begin
            cur_q[idx_q] <= nxt;
            if (idx_q == TAIL_IDX) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign angle_o       = angle_q;
  assign last_o        = last_q;

  `include "servo_slew_and_tail_wag_assert.svh"

  `SSW_ASSERT(a_last_tail, clk_i, rst_ni, out_valid_q && last_q |-> out_ch_q == 3'(TAIL_CH), "last word not on tail channel")
  `SSW_NEVER(a_no_pop_run, clk_i, rst_ni, state_q == S_RUN && pop_o, "queue popped during tick")
  `SSW_ASSERT(a_run_ends, clk_i, rst_ni, load && idx_q == TAIL_IDX |=> state_q == S_IDLE, "tick did not end after tail")

endmodule
